// File: rtl/hsdtc_pkg.sv
// ----------------------------------------------------------------------------
// hsdtc_pkg
// Shared widths, constants and register indexes for the thrust controller.
// ----------------------------------------------------------------------------
package hsdtc_pkg;

  // Throttle saturation in whole units, Q16.16 limit derived below
  localparam int unsigned ThrottleLimit = 150;
  localparam logic signed [31:0] THR_LIM = 32'(ThrottleLimit * 65536);

  localparam int unsigned IN_W  = 96;   // three 32-bit fields
  localparam int unsigned OUT_W = 176;  // 3x25 + 3x32 = 171, padded to bytes

  localparam int unsigned THR_W = 25;   // throttle field width
  localparam int unsigned PRD_W = 57;   // thrust product width

  // 180/pi in Q6.24
  localparam logic [29:0] DEG_PER_RAD = 30'd961263669;
  localparam logic signed [37:0] DEG360 = 38'sd23592960;
  localparam logic signed [38:0] DEG180 = 39'sd11796480;

  // Configuration register indexes
  localparam logic [2:0] REG_SPEED_REF   = 3'd0;
  localparam logic [2:0] REG_HDG_SETPT   = 3'd1;
  localparam logic [2:0] REG_DEPTH_REF   = 3'd2;
  localparam logic [2:0] REG_K_HEADING   = 3'd3;
  localparam logic [2:0] REG_K_SPEED     = 3'd4;
  localparam logic [2:0] REG_K_DEPTH     = 3'd5;
  localparam logic [2:0] REG_CT_FWD      = 3'd6;
  localparam logic [2:0] REG_CT_BACK     = 3'd7;

endpackage

// File: rtl/heading_speed_depth_thrust_control.sv
// ----------------------------------------------------------------------------
// heading_speed_depth_thrust_control
// Proportional heading/speed/depth controller with thrust allocation.
// ----------------------------------------------------------------------------
// Throughput: one word per cycle while m_axis_tready holds; eight register
//   stages, each holds a valid bit and advances when its successor is empty
//   or advancing, so bubbles are squeezed out while the output is stalled.
// Reset: rst_ni clears all valid bits and loads register defaults
//   (references 0, gains 655 / 655360 / 3276800, coefficients 1748).
// ----------------------------------------------------------------------------
module heading_speed_depth_thrust_control
  import hsdtc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  // config write port
  input  logic             cfg_we_i,
  input  logic [2:0]       cfg_idx_i,
  input  logic [31:0]      cfg_data_i,
  // input stream
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // measured_speed[31:0], measured_depth[63:32], yaw_angle[95:64]
  input  logic [IN_W-1:0]  s_axis_tdata,
  // output stream
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // port_throttle[24:0], star_throttle[49:25], vert_throttle[74:50],
  // surge_force[106:75], yaw_moment[138:107], heave_force[170:139], zero pad
  output logic [OUT_W-1:0] m_axis_tdata
);

  localparam int unsigned NSTG = 8;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic signed [31:0] speed_ref_q, depth_ref_q;
  logic        [24:0] hdg_setpt_q;
  logic        [23:0] k_heading_q, k_speed_q, k_depth_q, ct_fwd_q, ct_back_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_ref_q   <= '0;
      hdg_setpt_q   <= '0;
      depth_ref_q   <= '0;
      k_heading_q   <= 24'd655;
      k_speed_q     <= 24'd655360;
      k_depth_q     <= 24'd3276800;
      ct_fwd_q      <= 24'd1748;
      ct_back_q     <= 24'd1748;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SPEED_REF:   speed_ref_q   <= cfg_data_i;
        REG_HDG_SETPT:   hdg_setpt_q   <= cfg_data_i[24:0];
        REG_DEPTH_REF:   depth_ref_q   <= cfg_data_i;
        REG_K_HEADING:   k_heading_q   <= cfg_data_i[23:0];
        REG_K_SPEED:     k_speed_q     <= cfg_data_i[23:0];
        REG_K_DEPTH:     k_depth_q     <= cfg_data_i[23:0];
        REG_CT_FWD:      ct_fwd_q      <= cfg_data_i[23:0];
        REG_CT_BACK:     ct_back_q     <= cfg_data_i[23:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline flow control: stage k loads when it is empty or stage k+1 loads
  // --------------------------------------------------------------------------
  logic [NSTG-1:0] vld_q;
  logic [NSTG-1:0] en;

  always_comb begin
    en[NSTG-1] = !vld_q[NSTG-1] || m_axis_tready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) begin
        vld_q[0] <= s_axis_tvalid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  assign s_axis_tready = en[0];
  assign m_axis_tvalid = vld_q[NSTG-1];

  // --------------------------------------------------------------------------
  // Saturation helpers
  // --------------------------------------------------------------------------
  function automatic logic signed [31:0] clamp_thr(input logic signed [46:0] x);
    logic signed [46:0] lim;
    lim = 47'(THR_LIM);
    if (x > lim) begin
      return THR_LIM;
    end else if (x < -lim) begin
      return -THR_LIM;
    end
    return x[31:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [41:0] x);
    if (x > 42'sd2147483647) begin
      return 32'sh7FFF_FFFF;
    end else if (x < -42'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return x[31:0];
  endfunction

  // --------------------------------------------------------------------------
  // Stage 1: yaw to degrees product, speed and depth errors
  // --------------------------------------------------------------------------
  logic signed [31:0] spd_in, dep_in, yaw_in;
  logic signed [62:0] degp1_q;
  logic signed [32:0] serr1_q, derr1_q;

  assign spd_in = s_axis_tdata[31:0];
  assign dep_in = s_axis_tdata[63:32];
  assign yaw_in = s_axis_tdata[95:64];

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      degp1_q <= 63'(yaw_in) * 63'($signed({1'b0, DEG_PER_RAD}));
      serr1_q <= 33'(speed_ref_q) - 33'(spd_in);
      derr1_q <= 33'(depth_ref_q) - 33'(dep_in);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: round degrees to Q16.16, single wrap; speed/depth products
  // --------------------------------------------------------------------------
  logic signed [62:0] degr_sum;
  logic signed [37:0] deg_raw, deg_d;
  logic signed [37:0] deg2_q;
  logic signed [57:0] sterm2_q, vterm2_q;

  always_comb begin
    degr_sum = degp1_q + 63'sd8388608;  // half LSB, ties up
    deg_raw  = degr_sum[61:24];
    if (deg_raw < 38'sd0) begin
      deg_d = deg_raw + DEG360;
    end else if (deg_raw >= DEG360) begin
      deg_d = deg_raw - DEG360;
    end else begin
      deg_d = deg_raw;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      deg2_q   <= deg_d;
      sterm2_q <= 58'(serr1_q) * 58'($signed({1'b0, k_speed_q}));
      vterm2_q <= 58'(derr1_q) * 58'($signed({1'b0, k_depth_q}));
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: heading error and swap decision; vertical throttle
  // --------------------------------------------------------------------------
  logic signed [38:0] herr_d;
  logic signed [57:0] vr_sum;
  logic signed [38:0] herr3_q;
  logic               swap3_q;
  logic signed [57:0] sterm3_q;
  logic signed [31:0] uv3_q;

  assign herr_d = $signed({14'd0, hdg_setpt_q}) - 39'(deg2_q);
  assign vr_sum = vterm2_q + 58'sd32768;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      herr3_q  <= herr_d;
      // |err| >= 180 deg flips which side gets the positive heading term
      swap3_q  <= (herr_d >= DEG180) || (herr_d <= -DEG180);
      sterm3_q <= sterm2_q;
      uv3_q    <= clamp_thr(47'($signed(vr_sum[57:16])));
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: heading term
  // --------------------------------------------------------------------------
  logic signed [63:0] hterm4_q;
  logic               swap4_q;
  logic signed [57:0] sterm4_q;
  logic signed [31:0] uv4_q;

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      hterm4_q <= 64'(herr3_q) * 64'($signed({1'b0, k_heading_q}));
      swap4_q  <= swap3_q;
      sterm4_q <= sterm3_q;
      uv4_q    <= uv3_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: port and starboard sums in Q32
  // --------------------------------------------------------------------------
  logic signed [63:0] hport;
  logic signed [63:0] sump5_q, sums5_q;
  logic signed [31:0] uv5_q;

  assign hport = swap4_q ? hterm4_q : -hterm4_q;

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      sump5_q <= 64'(sterm4_q) + hport;
      sums5_q <= 64'(sterm4_q) - hport;
      uv5_q   <= uv4_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 6: halve, round to Q16.16, saturate
  // --------------------------------------------------------------------------
  logic signed [63:0] rp_sum, rs_sum;
  logic signed [31:0] up6_q, us6_q, uv6_q;

  assign rp_sum = sump5_q + 64'sd65536;
  assign rs_sum = sums5_q + 64'sd65536;

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      up6_q <= clamp_thr(rp_sum[63:17]);
      us6_q <= clamp_thr(rs_sum[63:17]);
      uv6_q <= uv5_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 7: thrust products
  // --------------------------------------------------------------------------
  logic signed [PRD_W-1:0] tp7, ts7, tv7;
  logic signed [31:0]      up7_q, us7_q, uv7_q;

  hsdtc_thrust u_thr_port (
    .clk_i     (clk_i),
    .en_i      (en[6]),
    .thr_i     (up6_q),
    .ct_fwd_i  (ct_fwd_q),
    .ct_back_i (ct_back_q),
    .thrust_o  (tp7)
  );

  hsdtc_thrust u_thr_star (
    .clk_i     (clk_i),
    .en_i      (en[6]),
    .thr_i     (us6_q),
    .ct_fwd_i  (ct_fwd_q),
    .ct_back_i (ct_back_q),
    .thrust_o  (ts7)
  );

  hsdtc_thrust u_thr_vert (
    .clk_i     (clk_i),
    .en_i      (en[6]),
    .thr_i     (uv6_q),
    .ct_fwd_i  (ct_fwd_q),
    .ct_back_i (ct_back_q),
    .thrust_o  (tv7)
  );

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      up7_q <= up6_q;
      us7_q <= us6_q;
      uv7_q <= uv6_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 8: forces, rounded once to Q16.16 and saturated; output register
  // --------------------------------------------------------------------------
  logic signed [57:0]      fx_sum, fn_sum, fz_sum;
  logic signed [31:0]      fx, fn, fz;
  logic        [OUT_W-1:0] tdata_q;

  assign fx_sum = 58'(tp7) + 58'(ts7) + 58'sd32768;
  assign fn_sum = 58'(ts7) - 58'(tp7) + 58'sd32768;
  assign fz_sum = 58'(tv7) + 58'sd32768;
  assign fx     = sat32(fx_sum[57:16]);
  assign fn     = sat32(fn_sum[57:16]);
  assign fz     = sat32(fz_sum[57:16]);

  always_ff @(posedge clk_i) begin
    if (en[7]) begin
      tdata_q <= {5'd0, fz, fn, fx,
                  uv7_q[THR_W-1:0], us7_q[THR_W-1:0], up7_q[THR_W-1:0]};
    end
  end

  assign m_axis_tdata = tdata_q;

endmodule

// File: rtl/hsdtc_thrust.sv
// ----------------------------------------------------------------------------
// hsdtc_thrust
// One thruster: picks forward or reverse coefficient by throttle sign and
// registers the exact Q32 thrust product.
// ----------------------------------------------------------------------------
module hsdtc_thrust
  import hsdtc_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic signed [31:0]      thr_i,
  input  logic        [23:0]      ct_fwd_i,
  input  logic        [23:0]      ct_back_i,
  output logic signed [PRD_W-1:0] thrust_o
);

  logic        [23:0]      coef;
  logic signed [PRD_W-1:0] thrust_d;
  logic signed [PRD_W-1:0] thrust_q;

  assign coef     = thr_i[31] ? ct_back_i : ct_fwd_i;
  assign thrust_d = PRD_W'(thr_i) * PRD_W'($signed({1'b0, coef}));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      thrust_q <= thrust_d;
    end
  end

  assign thrust_o = thrust_q;

endmodule

// File: rtl/hsdtc_checker.sv
// ----------------------------------------------------------------------------
// hsdtc_checker
// Port-level checks for the thrust controller, bound to the top level.
// ----------------------------------------------------------------------------
module hsdtc_checker
  import hsdtc_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             s_axis_tvalid,
  input logic             s_axis_tready,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [OUT_W-1:0] m_axis_tdata
);

  // stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word changed while stalled");

  // empty output stage means every stage can move
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  // horizontal throttles stay inside the limit
  a_thr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      ($signed(m_axis_tdata[24:0]) <= THR_LIM) &&
      ($signed(m_axis_tdata[24:0]) >= -THR_LIM) &&
      ($signed(m_axis_tdata[49:25]) <= THR_LIM) &&
      ($signed(m_axis_tdata[49:25]) >= -THR_LIM))
    else $error("throttle beyond limit");

  // zero vertical throttle gives zero heave
  a_heave_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[74:50] == '0) |-> m_axis_tdata[170:139] == '0)
    else $error("heave without vertical throttle");

endmodule

bind heading_speed_depth_thrust_control hsdtc_checker u_hsdtc_checker (.*);
